// ----- rtl/core/ffsa_pkg.sv -----
// Package for the first-fit segment allocator: opcodes, status codes, defaults.
// No dependencies.
package ffsa_pkg;

  localparam int unsigned MaxSegmentsDflt = 32;
  localparam int unsigned AddrBitsDflt    = 20;
  localparam int unsigned OwnerBitsDflt   = 16;

  localparam int unsigned OpW     = 2;
  localparam int unsigned OwnerW  = 16;
  localparam int unsigned SizeW   = 21;
  localparam int unsigned IndexW  = 5;
  localparam int unsigned StatusW = 3;
  localparam int unsigned StartW  = 20;
  localparam int unsigned CountW  = 6;

  localparam logic [SizeW-1:0] MemResetVal = 21'd1048576;

  typedef enum logic [OpW-1:0] {
    OpAlloc   = 2'd0,
    OpFree    = 2'd1,
    OpCompact = 2'd2,
    OpRead    = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    StOk      = 3'd0,
    StNoMem   = 3'd1,
    StNoOwner = 3'd2,
    StFull    = 3'd3,
    StBadArg  = 3'd4
  } status_e;

  typedef struct packed {
    logic [OpW-1:0]    opcode;
    logic [OwnerW-1:0] owner_id;
    logic [SizeW-1:0]  request_size;
    logic [IndexW-1:0] entry_index;
  } req_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [StartW-1:0]  alloc_start;
    logic               did_compact;
    logic [StartW-1:0]  entry_start;
    logic [SizeW-1:0]   entry_size;
    logic               entry_is_free;
    logic [OwnerW-1:0]  entry_owner;
    logic [CountW-1:0]  segment_count;
  } rsp_t;

endpackage

// ----- rtl/core/ffsa_if.sv -----
// Valid/ready channel interface carrying one payload of type T.
// Has no package dependency; the payload type is given by parameter T.
interface ffsa_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/first_fit_segment_allocator.sv -----
// First-fit segment allocator: one request at a time, table kept in a
// synchronous RAM (one write port, one read port, registered read data).
// Allocate, free and compact scan the table with one RAM access per cycle.
// The next request waits until the result has been taken by the receiver.
// Reset: asynchronous, active low; the table holds one free segment of 2^20 units.
module first_fit_segment_allocator
  import ffsa_pkg::*;
#(
  parameter int unsigned MAX_SEGMENTS = MaxSegmentsDflt,
  parameter int unsigned ADDR_BITS    = AddrBitsDflt,
  parameter int unsigned OWNER_BITS   = OwnerBitsDflt
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [SizeW-1:0] cfg_wdata_i,
  ffsa_if.sink             req_if,
  ffsa_if.source           rsp_if
);

  localparam int unsigned IdxW = $clog2(MAX_SEGMENTS);
  localparam int unsigned CntW = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned SzW  = ADDR_BITS + 1;
  localparam logic [SzW-1:0] MemLimit = SzW'(1) << ADDR_BITS;

  typedef struct packed {
    logic [ADDR_BITS-1:0]  start;
    logic [SzW-1:0]        size;
    logic                  free;
    logic [OWNER_BITS-1:0] owner;
  } ent_t;

  typedef enum logic [4:0] {
    SIdle, SReadWait, SReadDone,
    SFitRd, SFitChk, SSumChk,
    SCmpRd, SCmpChk, SCmpTail,
    SShRd, SShWr, SSplit,
    SRelRd, SRelChk, SMrgRd, SMrgChk, SMrgFlush,
    SDone
  } state_e;

  // table memory
  ent_t mem [MAX_SEGMENTS];
  logic            we;
  logic [IdxW-1:0] waddr, raddr;
  ent_t            wdata, rdata_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  state_e               state_q, state_d;
  logic [CntW-1:0]      used_q, used_d;
  logic [CntW-1:0]      i_q, i_d, k_q, k_d;
  logic [SzW-1:0]       units_q, units_d;
  logic [SzW-1:0]       acc_q, acc_d;
  logic [SzW:0]         sum_q, sum_d;
  ent_t                 hold_q, hold_d;
  logic                 hvld_q, hvld_d;
  logic                 flag_q, flag_d;
  logic                 cmp_q, cmp_d;
  logic                 alloc_q, alloc_d;
  logic                 init_q, init_d;
  req_t                 req_q, req_d;
  rsp_t                 rsp_q, rsp_d;
  logic                 rvld_q, rvld_d;
  logic [SzW-1:0]       rsize;
  logic [OWNER_BITS-1:0] rown;
  logic [SzW-1:0]       cfg_units;

  assign rsize = req_q.request_size[SzW-1:0] ;
  assign rown  = OWNER_BITS'(req_q.owner_id);
  assign req_if.ready = (state_q == SIdle) && !rvld_q && !init_q;
  assign rsp_if.valid = rvld_q;
  assign rsp_if.data  = rsp_q;

  always_comb begin
    if (cfg_wdata_i == '0) cfg_units = SzW'(1);
    else if ({1'b0, cfg_wdata_i} > (SizeW+1)'(MemLimit)) cfg_units = MemLimit;
    else cfg_units = SzW'(cfg_wdata_i);
  end

  // sequencer
  always_comb begin
    state_d = state_q; used_d = used_q; i_d = i_q; k_d = k_q;
    units_d = units_q; acc_d = acc_q; sum_d = sum_q; hold_d = hold_q;
    hvld_d = hvld_q; flag_d = flag_q; cmp_d = cmp_q; alloc_d = alloc_q;
    init_d = 1'b0; req_d = req_q; rsp_d = rsp_q; rvld_d = rvld_q;
    we = 1'b0; waddr = '0; wdata = '0; raddr = IdxW'(i_q);

    if (rvld_q && rsp_if.ready) rvld_d = 1'b0;

    case (state_q)
      SIdle: begin
        if (init_q) begin
          we = 1'b1; waddr = '0;
          wdata = '{start: '0, size: units_q, free: 1'b1, owner: '0};
        end else if (req_if.valid && req_if.ready) begin
          req_d = req_if.data;
          rsp_d = '0;
          cmp_d = 1'b0; i_d = '0; k_d = '0;
          case (op_e'(req_if.data.opcode))
            OpAlloc: begin
              if (req_if.data.request_size == '0 ||
                  {1'b0, req_if.data.request_size} > (SizeW+1)'(MemLimit)) begin
                if (req_if.data.request_size == '0) begin
                  rsp_d.status = StBadArg; state_d = SDone;
                end else begin
                  rsp_d.status = StNoMem; state_d = SDone;
                end
              end else begin
                sum_d = '0; state_d = SFitRd;
              end
            end
            OpFree: begin flag_d = 1'b0; state_d = SRelRd; end
            OpCompact: begin alloc_d = 1'b0; acc_d = '0; state_d = SCmpRd; end
            default: begin
              if (CntW'(req_if.data.entry_index) < used_q &&
                  32'(req_if.data.entry_index) < MAX_SEGMENTS) begin
                state_d = SReadWait;
              end else begin
                rsp_d.status = StBadArg; state_d = SDone;
              end
            end
          endcase
        end
      end
      SReadWait: begin
        raddr = IdxW'(req_q.entry_index); state_d = SReadDone;
      end
      SReadDone: begin
        rsp_d.entry_start   = StartW'(rdata_q.start);
        rsp_d.entry_size    = SizeW'(rdata_q.size);
        rsp_d.entry_is_free = rdata_q.free;
        rsp_d.entry_owner   = OwnerW'(rdata_q.owner);
        state_d = SDone;
      end
      // first-fit scan; sum free space alongside
      SFitRd: begin
        if (i_q >= used_q) begin
          state_d = SSumChk;
        end else begin
          state_d = SFitChk;
        end
      end
      SFitChk: begin
        if (rdata_q.free && rdata_q.size >= rsize) begin
          hold_d = rdata_q; k_d = i_q;
          if (rdata_q.size == rsize) begin
            we = 1'b1; waddr = IdxW'(i_q);
            wdata = rdata_q; wdata.free = 1'b0; wdata.owner = rown;
            rsp_d.alloc_start = StartW'(rdata_q.start);
            state_d = SDone;
          end else if (used_q >= CntW'(MAX_SEGMENTS)) begin
            rsp_d.status = StFull; state_d = SDone;
          end else begin
            i_d = used_q; hvld_d = 1'b0; state_d = SShRd;
          end
        end else begin
          if (rdata_q.free) sum_d = sum_q + (SzW+1)'(rdata_q.size);
          i_d = i_q + 1'b1; state_d = SFitRd;
        end
      end
      SSumChk: begin
        if (sum_q >= (SzW+1)'(rsize) && !cmp_q) begin
          alloc_d = 1'b1; acc_d = '0; i_d = '0; k_d = '0; state_d = SCmpRd;
        end else begin
          rsp_d.status = StNoMem; state_d = SDone;
        end
      end
      // compaction: copy owned entries down, then append free tail
      SCmpRd: begin
        if (i_q >= used_q) state_d = SCmpTail;
        else state_d = SCmpChk;
      end
      SCmpChk: begin
        if (!rdata_q.free) begin
          we = 1'b1; waddr = IdxW'(k_q);
          wdata = rdata_q; wdata.start = ADDR_BITS'(acc_q);
          acc_d = acc_q + rdata_q.size; k_d = k_q + 1'b1;
        end
        i_d = i_q + 1'b1; raddr = IdxW'(i_q + 1'b1); state_d = SCmpRd;
      end
      SCmpTail: begin
        used_d = k_q;
        if (acc_q < units_q && k_q < CntW'(MAX_SEGMENTS)) begin
          we = 1'b1; waddr = IdxW'(k_q);
          wdata = '{start: ADDR_BITS'(acc_q), size: units_q - acc_q,
                    free: 1'b1, owner: '0};
          used_d = k_q + 1'b1;
        end
        cmp_d = 1'b1; rsp_d.did_compact = 1'b1;
        if (alloc_q) begin
          sum_d = '0; i_d = '0; state_d = SFitRd;
        end else begin
          state_d = SDone;
        end
      end
      // split: shift entries above k up by one, top down
      SShRd: begin
        if (i_q > k_q + 1'b1) begin
          raddr = IdxW'(i_q - 1'b1); state_d = SShWr;
        end else begin
          state_d = SSplit;
        end
      end
      SShWr: begin
        we = 1'b1; waddr = IdxW'(i_q); wdata = rdata_q;
        i_d = i_q - 1'b1; state_d = SShRd;
      end
      SSplit: begin
        if (!hvld_q) begin
          we = 1'b1; waddr = IdxW'(k_q + 1'b1);
          wdata = '{start: hold_q.start + ADDR_BITS'(rsize),
                    size: hold_q.size - rsize, free: 1'b1, owner: '0};
          hvld_d = 1'b1;
        end else begin
          we = 1'b1; waddr = IdxW'(k_q);
          wdata = '{start: hold_q.start, size: rsize, free: 1'b0, owner: rown};
          used_d = used_q + 1'b1;
          rsp_d.alloc_start = StartW'(hold_q.start);
          state_d = SDone;
        end
      end
      // release pass: mark owner's entries free
      SRelRd: begin
        if (i_q >= used_q) begin
          if (flag_q) begin
            i_d = '0; k_d = '0; hvld_d = 1'b0; state_d = SMrgRd;
          end else begin
            rsp_d.status = StNoOwner; state_d = SDone;
          end
        end else begin
          state_d = SRelChk;
        end
      end
      SRelChk: begin
        if (!rdata_q.free && rdata_q.owner == rown) begin
          we = 1'b1; waddr = IdxW'(i_q);
          wdata = rdata_q; wdata.free = 1'b1; wdata.owner = '0;
          flag_d = 1'b1;
        end
        i_d = i_q + 1'b1; raddr = IdxW'(i_q + 1'b1); state_d = SRelRd;
      end
      // merge pass: hold the last output entry, flush when a new one starts
      SMrgRd: begin
        if (i_q >= used_q) state_d = SMrgFlush;
        else state_d = SMrgChk;
      end
      SMrgChk: begin
        if (hvld_q && hold_q.free && rdata_q.free) begin
          hold_d.size = hold_q.size + rdata_q.size;
        end else begin
          if (hvld_q) begin
            we = 1'b1; waddr = IdxW'(k_q); wdata = hold_q; k_d = k_q + 1'b1;
          end
          hold_d = rdata_q; hvld_d = 1'b1;
        end
        i_d = i_q + 1'b1; raddr = IdxW'(i_q + 1'b1); state_d = SMrgRd;
      end
      SMrgFlush: begin
        we = 1'b1; waddr = IdxW'(k_q); wdata = hold_q;
        used_d = k_q + 1'b1; state_d = SDone;
      end
      SDone: begin
        if (!rvld_q) begin
          rsp_d.segment_count = CountW'(used_q);
          rvld_d = 1'b1; state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase

    if (cfg_we_i) begin
      units_d = cfg_units; used_d = CntW'(1); init_d = 1'b1;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      used_q  <= CntW'(1);
      units_q <= MemLimit;
      init_q  <= 1'b1;
      rvld_q  <= 1'b0;
      i_q <= '0; k_q <= '0; hvld_q <= 1'b0; flag_q <= 1'b0;
      cmp_q <= 1'b0; alloc_q <= 1'b0;
    end else begin
      state_q <= state_d; used_q <= used_d; units_q <= units_d;
      init_q <= init_d; rvld_q <= rvld_d; i_q <= i_d; k_q <= k_d;
      hvld_q <= hvld_d; flag_q <= flag_d; cmp_q <= cmp_d; alloc_q <= alloc_d;
    end
  end

  // datapath holding registers
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; sum_q <= sum_d; hold_q <= hold_d;
    req_q <= req_d; rsp_q <= rsp_d;
  end

`ifndef ASSERT_OFF
  a_used_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CntW'(MAX_SEGMENTS)) else $error("segment count over table size");
  a_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_if.valid && req_if.ready) |=> !req_if.ready) else $error("second request taken");
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_if.valid && !rsp_if.ready) |=> rsp_if.valid && $stable(rsp_q))
    else $error("result dropped");
`endif

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for first_fit_segment_allocator: a behavioral copy of the
// segment table predicts each response, compared as a whole with the actual one.
// Depends on ffsa_pkg, ffsa_if and the allocator RTL.
`timescale 1ns / 1ps

module testbench;
  import ffsa_pkg::*;

  localparam int NumSeg = 32;
  localparam longint MemMax = 64'd1 << 20;
  localparam int IdleLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [SizeW-1:0] cfg_wdata_i = '0;

  ffsa_if #(.T(req_t)) req_if ();
  ffsa_if #(.T(rsp_t)) rsp_if ();

  first_fit_segment_allocator dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .req_if, .rsp_if
  );

  always #10 clk_i = ~clk_i;

  // Shadow segment table
  longint tbl_start [NumSeg];
  longint tbl_size [NumSeg];
  bit tbl_free [NumSeg];
  longint tbl_owner [NumSeg];
  int tbl_used;
  longint mem_units;

  rsp_t rsp_expected_q [$];
  int mismatch_count = 0;
  bit timed_out = 1'b0;
  bit hold_rsp = 1'b0;
  int idle_cycles = 0;
  int rsp_wait = 0;

  function automatic void table_reinit(logic [SizeW-1:0] value);
    longint v;
    v = value;
    if (v == 0) v = 1;
    if (v > MemMax) v = MemMax;
    mem_units = v;
    for (int i = 0; i < NumSeg; i++) begin
      tbl_start[i] = 0; tbl_size[i] = 0; tbl_free[i] = 0; tbl_owner[i] = 0;
    end
    tbl_size[0] = mem_units;
    tbl_free[0] = 1'b1;
    tbl_used = 1;
  endfunction

  function automatic void move_entry(int dst, int src);
    tbl_start[dst] = tbl_start[src];
    tbl_size[dst] = tbl_size[src];
    tbl_free[dst] = tbl_free[src];
    tbl_owner[dst] = tbl_owner[src];
  endfunction

  function automatic void squeeze_table();
    int k;
    longint pos;
    k = 0;
    pos = 0;
    for (int i = 0; i < tbl_used; i++) begin
      if (!tbl_free[i]) begin
        move_entry(k, i);
        tbl_start[k] = pos;
        pos += tbl_size[k];
        k++;
      end
    end
    if (pos < mem_units && k < NumSeg) begin
      tbl_start[k] = pos; tbl_size[k] = mem_units - pos;
      tbl_free[k] = 1'b1; tbl_owner[k] = 0;
      k++;
    end
    tbl_used = k;
  endfunction

  function automatic int find_fit(longint sz);
    for (int i = 0; i < tbl_used; i++)
      if (tbl_free[i] && tbl_size[i] >= sz) return i;
    return -1;
  endfunction

  // Apply one request to the shadow table and return the response it gives
  function automatic rsp_t allocator_response(req_t rq);
    rsp_t r;
    int loc, k;
    longint sz, free_sum;
    bit found;
    r = '0;
    r.status = StOk;
    sz = rq.request_size;
    case (op_e'(rq.opcode))
      OpAlloc: begin
        if (sz == 0) begin
          r.status = StBadArg;
        end else begin
          loc = find_fit(sz);
          if (loc < 0) begin
            free_sum = 0;
            for (int i = 0; i < tbl_used; i++) if (tbl_free[i]) free_sum += tbl_size[i];
            if (free_sum >= sz) begin
              squeeze_table();
              r.did_compact = 1'b1;
              loc = find_fit(sz);
            end
          end
          if (loc < 0) begin
            r.status = StNoMem;
          end else if (tbl_size[loc] != sz && tbl_used >= NumSeg) begin
            r.status = StFull;
          end else begin
            if (tbl_size[loc] != sz) begin
              for (int i = tbl_used; i > loc + 1; i--) move_entry(i, i - 1);
              tbl_start[loc+1] = tbl_start[loc] + sz;
              tbl_size[loc+1] = tbl_size[loc] - sz;
              tbl_free[loc+1] = 1'b1;
              tbl_owner[loc+1] = 0;
              tbl_size[loc] = sz;
              tbl_used++;
            end
            tbl_free[loc] = 1'b0;
            tbl_owner[loc] = rq.owner_id;
            r.alloc_start = StartW'(tbl_start[loc]);
          end
        end
      end
      OpFree: begin
        found = 1'b0;
        for (int i = 0; i < tbl_used; i++) begin
          if (!tbl_free[i] && tbl_owner[i] == rq.owner_id) begin
            tbl_free[i] = 1'b1; tbl_owner[i] = 0; found = 1'b1;
          end
        end
        if (!found) begin
          r.status = StNoOwner;
        end else begin
          k = 0;
          for (int i = 0; i < tbl_used; i++) begin
            if (tbl_free[i] && k > 0 && tbl_free[k-1]) begin
              tbl_size[k-1] += tbl_size[i];
            end else begin
              if (k != i) move_entry(k, i);
              k++;
            end
          end
          for (int i = k; i < NumSeg; i++) begin
            tbl_start[i] = 0; tbl_size[i] = 0; tbl_free[i] = 0; tbl_owner[i] = 0;
          end
          tbl_used = k;
        end
      end
      OpCompact: begin
        squeeze_table();
        r.did_compact = 1'b1;
      end
      default: begin
        if (rq.entry_index < tbl_used) begin
          r.entry_start = StartW'(tbl_start[rq.entry_index]);
          r.entry_size = SizeW'(tbl_size[rq.entry_index]);
          r.entry_is_free = tbl_free[rq.entry_index];
          r.entry_owner = OwnerW'(tbl_owner[rq.entry_index]);
        end else begin
          r.status = StBadArg;
        end
      end
    endcase
    r.segment_count = CountW'(tbl_used);
    return r;
  endfunction

  // Offer one request after a random gap, predict at acceptance;
  // drop valid at the start of a gap, so a request offered with no gap
  // replaces the one just taken within the same edge
  task automatic send_request(op_e op, logic [OwnerW-1:0] owner,
                              logic [SizeW-1:0] sz, logic [IndexW-1:0] idx);
    req_t rq;
    int gap;
    gap = $urandom_range(7);
    if ($urandom_range(3) == 0) gap = 0;
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rq.opcode = op;
    rq.owner_id = owner;
    rq.request_size = sz;
    rq.entry_index = idx;
    req_if.valid <= 1'b1;
    req_if.data <= rq;
    do @(posedge clk_i); while (!req_if.ready);
    rsp_expected_q.push_back(allocator_response(rq));
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (rsp_expected_q.size() != 0) @(posedge clk_i);
    repeat (250) @(posedge clk_i);
  endtask

  task automatic write_memory_size(logic [SizeW-1:0] value);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    table_reinit(value);
  endtask

  // Drive receiver ready: wait a drawn number of cycles per response,
  // unless a hold-off is active
  always @(posedge clk_i) begin
    if (rsp_if.valid && rsp_if.ready) rsp_wait = $urandom_range(7);
    else if (rsp_if.valid && rsp_wait > 0) rsp_wait = rsp_wait - 1;
    rsp_if.ready <= !hold_rsp && (rsp_wait == 0);
  end

  // Compare each response with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (rsp_expected_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected response %p", rsp_if.data);
      end else begin
        automatic rsp_t exp_rsp = rsp_expected_q.pop_front();
        if (rsp_if.data !== exp_rsp) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected %p actual %p", exp_rsp, rsp_if.data);
        end
      end
    end
  end

  // Watchdog on cycles with no handshake
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) timed_out = 1'b1;
  end

  task automatic test_directed();
    send_request(OpRead, 16'hffff, '0, 5'd0);
    send_request(OpRead, '0, '0, 5'd31);
    send_request(OpAlloc, 16'd1, 21'd0, '0);
    send_request(OpAlloc, 16'd1, 21'd1048577, '0);
    send_request(OpAlloc, 16'd7, 21'd100, '0);
    send_request(OpAlloc, 16'hffff, 21'd200, '0);
    send_request(OpAlloc, 16'd7, 21'd50, '0);
    send_request(OpFree, 16'd9, '0, '0);
    send_request(OpFree, 16'd7, '0, '0);
    send_request(OpRead, '0, '0, 5'd0);
    send_request(OpCompact, '0, '0, '0);
    send_request(OpRead, '0, '0, 5'd1);
    send_request(OpAlloc, 16'd3, 21'd1048276, '0);
    send_request(OpCompact, '0, '0, '0);
    send_request(OpFree, 16'hffff, '0, '0);
    send_request(OpFree, 16'd3, '0, '0);
    send_request(OpAlloc, 16'd0, 21'h1fffff, '0);
    send_request(OpAlloc, 16'd0, 21'd1048576, '0);
    send_request(OpRead, '0, '0, 5'd0);
  endtask

  // Fill the table to the limit with small blocks, then punch holes
  task automatic test_table_full();
    write_memory_size(21'd64);
    for (int i = 0; i < 34; i++) send_request(OpAlloc, 16'(i % 4), 21'd1, '0);
    send_request(OpRead, '0, '0, 5'd31);
    send_request(OpFree, 16'd1, '0, '0);
    send_request(OpAlloc, 16'd5, 21'd2, '0);
    send_request(OpAlloc, 16'd5, 21'd20, '0);
  endtask

  task automatic test_memory_sizes();
    write_memory_size(21'd0);
    send_request(OpAlloc, 16'd1, 21'd1, '0);
    send_request(OpAlloc, 16'd1, 21'd1, '0);
    send_request(OpRead, '0, '0, 5'd0);
    write_memory_size(21'h1fffff);
    send_request(OpRead, '0, '0, 5'd0);
    write_memory_size(21'd1);
    send_request(OpRead, '0, '0, 5'd0);
  endtask

  // Random traffic: mostly allocate/free, with sizes small, scaled to memory or fully random
  task automatic test_random(int count, logic [SizeW-1:0] mem);
    int pick;
    logic [SizeW-1:0] sz;
    write_memory_size(mem);
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      case ($urandom_range(3))
        0: sz = SizeW'($urandom_range(4));
        1: sz = SizeW'($urandom_range(32, 1));
        2: sz = SizeW'($urandom_range(int'(mem) / 4 + 1, 1));
        default: sz = SizeW'($urandom);
      endcase
      if (pick < 50)
        send_request(OpAlloc, 16'($urandom_range(7)) ^ ($urandom_range(1) ? 16'hfff0 : 16'h0),
                     sz, 5'($urandom));
      else if (pick < 75)
        send_request(OpFree, 16'($urandom_range(7)) ^ ($urandom_range(1) ? 16'hfff0 : 16'h0),
                     sz, 5'($urandom));
      else if (pick < 80)
        send_request(OpCompact, 16'($urandom), sz, 5'($urandom));
      else
        send_request(OpRead, 16'($urandom), sz, 5'($urandom));
    end
  endtask

  // Hold the response side off while requests keep coming
  task automatic test_backpressure();
    fork
      begin
        hold_rsp <= 1'b1;
        repeat (600) @(posedge clk_i);
        hold_rsp <= 1'b0;
      end
      for (int i = 0; i < 8; i++) send_request(OpRead, '0, '0, 5'($urandom_range(3)));
    join
  endtask

  initial begin
    req_if.valid = 1'b0;
    req_if.data = '0;
    rsp_if.ready = 1'b0;
    table_reinit(MemResetVal);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    fork
      begin
        test_directed();
        test_backpressure();
        test_table_full();
        test_memory_sizes();
        test_random(400, 21'd64);
        test_random(400, 21'd1000);
        test_random(400, 21'd1048576);
        test_random(300, 21'd37);
        wait_drained();
      end
      wait (timed_out);
    join_any
    if (timed_out) begin
      $display("== FAIL ==");
    end else if (mismatch_count == 0 && rsp_expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/ffsa_pkg.sv
rtl/core/ffsa_if.sv
rtl/core/first_fit_segment_allocator.sv
bench/testbench.sv
